[rtl/bsl_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Button press detector package
// Shared widths, register indexes, result codes and types.
// ---------------------------------------------------------------------------
package bsl_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int COUNT_BITS  = 12;
    localparam int REG_BITS    = 12;
    localparam int IDX_BITS    = 2;
    localparam int BTN_BITS    = 3;
    localparam int CODE_BITS   = 4;
    localparam int CMP_BITS    = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [IDX_BITS-1:0] REG_SHORT_TICKS   = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_LONG_TICKS    = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_RELEASE_TICKS = 2'd2;

    localparam logic [REG_BITS-1:0] RST_SHORT_TICKS   = 12'd3;
    localparam logic [REG_BITS-1:0] RST_LONG_TICKS    = 12'd200;
    localparam logic [REG_BITS-1:0] RST_RELEASE_TICKS = 12'd3;

    localparam logic [CODE_BITS-1:0] CODE_NONE     = 4'd0;
    localparam logic [CODE_BITS-1:0] CODE_LONG_OFS = 4'd5;
    localparam logic [BTN_BITS-1:0]  BTN_NONE      = 3'd0;

    typedef logic [NUM_BUTTONS-1:0] t_levels;

    typedef struct packed {
        logic [REG_BITS-1:0] short_ticks;
        logic [REG_BITS-1:0] long_ticks;
        logic [REG_BITS-1:0] release_ticks;
    } t_cfg;

    typedef struct packed {
        logic [CODE_BITS-1:0] click_code;
        logic [BTN_BITS-1:0]  active_button;
    } t_result;

endpackage
`default_nettype wire

[rtl/bsl_in_stage.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Input stage
// Registers one request of button levels and tracks its valid flag.
// ---------------------------------------------------------------------------
module bsl_in_stage
    import bsl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_levels i_levels,
    input  wire logic    i_advance,
    output logic         o_ready,
    output logic         o_valid,
    output t_levels      o_levels
);

    logic    r_valid;
    t_levels r_levels;
    logic    w_load;

    assign o_ready  = !r_valid || i_advance;
    assign w_load   = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_levels = r_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_levels <= i_levels;
        end
    end

endmodule
`default_nettype wire

[rtl/bsl_press_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Press tracking core
// Holds the per-button counters and the tracked button, and works out one
// scan tick in combinational next-state logic.
// ---------------------------------------------------------------------------
module bsl_press_core
    import bsl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire t_levels i_levels,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    logic [COUNT_BITS-1:0] r_press [NUM_BUTTONS];
    logic [COUNT_BITS-1:0] r_rel   [NUM_BUTTONS];
    logic [COUNT_BITS-1:0] n_press [NUM_BUTTONS];
    logic [COUNT_BITS-1:0] n_rel   [NUM_BUTTONS];
    logic [BTN_BITS-1:0]   r_track;
    logic [BTN_BITS-1:0]   n_track;
    logic                  r_short_seen;
    logic                  n_short_seen;
    logic                  r_long_seen;
    logic                  n_long_seen;

    logic [NUM_BUTTONS:0]  w_below;
    logic [BTN_BITS-1:0]   w_trk;
    logic [COUNT_BITS-1:0] w_pc_sel;
    logic [COUNT_BITS-1:0] w_rc_sel;
    logic [COUNT_BITS-1:0] w_hold;
    logic                  w_hit_long;
    logic                  w_hit_short;
    logic                  w_hit_end;
    logic [CODE_BITS-1:0]  w_code;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    always_comb begin
        w_below[0] = 1'b0;
        w_trk      = r_track;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            w_below[b+1] = w_below[b] | i_levels[b];
            n_press[b]   = r_press[b];
            n_rel[b]     = r_rel[b];
            if (i_levels[b]) begin
                n_rel[b]   = '0;
                n_press[b] = sat_inc(r_press[b]);
                w_trk      = BTN_BITS'(b + 1);
            end else if (r_track == BTN_BITS'(b + 1) && !w_below[b]) begin
                n_press[b] = '0;
                n_rel[b]   = sat_inc(r_rel[b]);
            end
        end

        w_pc_sel = '0;
        w_rc_sel = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (w_trk == BTN_BITS'(b + 1)) begin
                w_pc_sel = n_press[b];
                w_rc_sel = n_rel[b];
            end
        end

        w_hold = (CMP_BITS'(i_cfg.long_ticks) > CMP_BITS'(CNT_MAX)) ?
                 CNT_MAX : COUNT_BITS'(i_cfg.long_ticks);
        w_hit_long  = (w_trk != BTN_NONE) &&
                      (CMP_BITS'(w_pc_sel) > CMP_BITS'(i_cfg.long_ticks));
        w_hit_short = (w_trk != BTN_NONE) && !w_hit_long &&
                      (CMP_BITS'(w_pc_sel) > CMP_BITS'(i_cfg.short_ticks));
        w_hit_end   = (w_trk != BTN_NONE) &&
                      (CMP_BITS'(w_rc_sel) > CMP_BITS'(i_cfg.release_ticks));

        w_code       = CODE_NONE;
        n_long_seen  = r_long_seen;
        n_short_seen = r_short_seen;
        n_track      = w_trk;
        if (w_hit_long) begin
            if (!r_long_seen) begin
                w_code = CODE_BITS'(w_trk) + CODE_LONG_OFS;
            end
            n_long_seen = 1'b1;
        end else if (w_hit_short) begin
            if (!r_short_seen) begin
                w_code = CODE_BITS'(w_trk);
            end
            n_short_seen = 1'b1;
        end
        if (w_hit_end) begin
            n_track      = BTN_NONE;
            n_short_seen = 1'b0;
            n_long_seen  = 1'b0;
        end

        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (w_trk == BTN_BITS'(b + 1)) begin
                if (w_hit_long) begin
                    n_press[b] = w_hold;
                end
                if (w_hit_end) begin
                    n_rel[b] = '0;
                end
            end
        end
    end

    assign o_result.click_code    = w_code;
    assign o_result.active_button = n_track;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_press[b] <= '0;
                r_rel[b]   <= '0;
            end
            r_track      <= BTN_NONE;
            r_short_seen <= 1'b0;
            r_long_seen  <= 1'b0;
        end else if (i_en) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_press[b] <= n_press[b];
                r_rel[b]   <= n_rel[b];
            end
            r_track      <= n_track;
            r_short_seen <= n_short_seen;
            r_long_seen  <= n_long_seen;
        end
    end

endmodule
`default_nettype wire

[rtl/button_short_long_press_detector.sv]
`default_nettype none
// The result register is loaded from the input register when its request advances;
// one request per cycle while the result register is empty or being read. The whole
// counter update for a tick is done combinationally between the two registers.
// Reset (synchronous, active low) clears all counters, the tracked button and
// both press flags, and loads the thresholds with their default values.
// ---------------------------------------------------------------------------
// Button short/long press detector
// Tracks five buttons per scan tick and reports short and long presses.
// ---------------------------------------------------------------------------
module button_short_long_press_detector
    import bsl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_hour_level,
    input  wire logic                 i_up_level,
    input  wire logic                 i_down_level,
    input  wire logic                 i_select_level,
    input  wire logic                 i_clear_level,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [CODE_BITS-1:0]      o_click_code,
    output logic [BTN_BITS-1:0]       o_active_button,
    input  wire logic                 i_cfg_we,
    input  wire logic [IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [REG_BITS-1:0]  i_cfg_wdata
);

    t_cfg    r_cfg;
    t_levels w_levels;
    t_levels w_st_levels;
    logic    w_st_valid;
    logic    w_advance;
    t_result w_result;
    t_result r_result;
    logic    r_out_valid;

    assign w_levels = {i_clear_level, i_select_level, i_down_level, i_up_level,
                       i_hour_level};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ticks   <= RST_SHORT_TICKS;
            r_cfg.long_ticks    <= RST_LONG_TICKS;
            r_cfg.release_ticks <= RST_RELEASE_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SHORT_TICKS: begin
                    r_cfg.short_ticks <= i_cfg_wdata;
                end
                REG_LONG_TICKS: begin
                    r_cfg.long_ticks <= i_cfg_wdata;
                end
                REG_RELEASE_TICKS: begin
                    r_cfg.release_ticks <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_advance = w_st_valid && (!r_out_valid || i_ready);

    bsl_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_levels  (w_levels),
        .i_advance (w_advance),
        .o_ready   (o_ready),
        .o_valid   (w_st_valid),
        .o_levels  (w_st_levels)
    );

    bsl_press_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_levels (w_st_levels),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_click_code    = r_result.click_code;
    assign o_active_button = r_result.active_button;

    // A reported press always belongs to the button that is still tracked.
    a_code_matches_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_click_code != CODE_NONE) |->
        (o_click_code == CODE_BITS'(o_active_button) ||
         o_click_code == CODE_BITS'(o_active_button) + CODE_LONG_OFS))
        else $error("click code does not match the active button");

    // With the result register empty, the input side never stalls.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while the result register is empty");

    // The tracked button is always one of the five buttons or none.
    a_button_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_active_button <= 3'd5))
        else $error("active button out of range");

endmodule
`default_nettype wire
